// File: design/lcf_pkg.sv
// shared types and constants of the line constraint force block
package lcf_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int FORCE_WIDTH = 24;
	localparam int CFG_WIDTH   = 16;
	localparam int CFG_IDX_W   = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EFFECT_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPRING_STIFFNESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN     = 2'd2;

	// spring gain is scaled by 100 so both terms share the 0.01 unit
	localparam int K_SCALE = 100;
	// half of the rounding denominator, per unit of squared length
	localparam int HALF_SCALE = 100000;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] tool_pos_x;
		logic signed [COORD_WIDTH-1:0] tool_pos_y;
		logic signed [COORD_WIDTH-1:0] tool_pos_z;
		logic signed [COORD_WIDTH-1:0] tool_vel_x;
		logic signed [COORD_WIDTH-1:0] tool_vel_y;
		logic signed [COORD_WIDTH-1:0] tool_vel_z;
		logic signed [COORD_WIDTH-1:0] line_a_x;
		logic signed [COORD_WIDTH-1:0] line_a_y;
		logic signed [COORD_WIDTH-1:0] line_a_z;
		logic signed [COORD_WIDTH-1:0] line_b_x;
		logic signed [COORD_WIDTH-1:0] line_b_y;
		logic signed [COORD_WIDTH-1:0] line_b_z;
	} sample_t;

	typedef struct packed {
		logic signed [FORCE_WIDTH-1:0] force_x;
		logic signed [FORCE_WIDTH-1:0] force_y;
		logic signed [FORCE_WIDTH-1:0] force_z;
		logic                          degenerate_line;
	} force_t;

endpackage

// File: design/line_constraint_force_top.sv
// top level of the line constraint force pipeline
//
// virtual fixture that pulls a tool onto the line through two points.
// sample channel: sample_valid / sample_word / sample_stall carries tool
// position, tool velocity and both line endpoints as one word.
// force channel: force_valid / force_word / force_stall returns one word per
// sample: spring plus damping force in mN, saturated, and a degenerate flag.
// config port: cfg_we writes cfg_data into register cfg_index (enable,
// stiffness, damping); write only while no sample is in flight.
// throughput: one sample per cycle while the receiver does not stall, fully pipelined.
// pipeline: ten stages of products and sums, one restoring division stage per
// force bit, one output register.
// reset clears the configuration registers and all valid bits; the pipeline
// comes out of reset empty and ready.
// when the receiver stalls with a word waiting, the whole pipeline holds and
// sample_stall goes high; nothing is dropped or repeated.
module line_constraint_force_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	input  lcf_pkg::sample_t                  sample_word,
	output logic                              sample_stall,
	output logic                              force_valid,
	output lcf_pkg::force_t                   force_word,
	input  logic                              force_stall,
	input  logic                              cfg_we,
	input  logic [lcf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lcf_pkg::CFG_WIDTH-1:0]     cfg_data
);

	localparam int CW = lcf_pkg::COORD_WIDTH;
	localparam int FW = lcf_pkg::FORCE_WIDTH;
	localparam int DW = CW + 1;          // endpoint and offset differences
	localparam int SQW = 2 * DW;         // single coordinate products
	localparam int LW = 2 * CW + 3;      // squared length and dot products
	localparam int MW = LW + DW;         // second level products
	localparam int PW = MW + 1;          // spring and normal vectors
	localparam int KW = 24;              // scaled stiffness, signed
	localparam int CQW = 17;             // damping gain, signed
	localparam int HCW = 18;             // rounding constant, signed
	localparam int HW = LW + HCW;        // 100000 * squared length
	localparam int XW = PW + KW + 1;     // combined numerator
	localparam int NW = ((XW + 1 > HW + FW + 1) ? XW + 1 : HW + FW + 1) + 1;

	// configuration
	logic                         effect_enable_q;
	logic [lcf_pkg::CFG_WIDTH-1:0] spring_stiffness_q;
	logic [lcf_pkg::CFG_WIDTH-1:0] damping_gain_q;
	logic [KW-1:0]                kq_u;
	logic signed [KW-1:0]         kq;
	logic signed [CQW-1:0]        cq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			effect_enable_q    <= 1'b0;
			spring_stiffness_q <= '0;
			damping_gain_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lcf_pkg::REG_EFFECT_ENABLE:    effect_enable_q    <= cfg_data[0];
				lcf_pkg::REG_SPRING_STIFFNESS: spring_stiffness_q <= cfg_data;
				lcf_pkg::REG_DAMPING_GAIN:     damping_gain_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign kq_u = KW'(spring_stiffness_q) * KW'(lcf_pkg::K_SCALE);
	assign kq   = $signed(kq_u);
	assign cq   = $signed({1'b0, damping_gain_q});

	// global advance: the pipeline moves unless a finished word is held
	logic en;
	logic out_valid_q;
	lcf_pkg::force_t out_q;

	assign en           = !out_valid_q || !force_stall;
	assign sample_stall = !en;

	// unpack the input word per axis
	logic signed [CW-1:0] in_p [3];
	logic signed [CW-1:0] in_v [3];
	logic signed [CW-1:0] in_a [3];
	logic signed [CW-1:0] in_b [3];

	always_comb begin
		in_p[0] = sample_word.tool_pos_x;
		in_p[1] = sample_word.tool_pos_y;
		in_p[2] = sample_word.tool_pos_z;
		in_v[0] = sample_word.tool_vel_x;
		in_v[1] = sample_word.tool_vel_y;
		in_v[2] = sample_word.tool_vel_z;
		in_a[0] = sample_word.line_a_x;
		in_a[1] = sample_word.line_a_y;
		in_a[2] = sample_word.line_a_z;
		in_b[0] = sample_word.line_b_x;
		in_b[1] = sample_word.line_b_y;
		in_b[2] = sample_word.line_b_z;
	end

	// valid and degenerate flags per stage
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9;
	logic deg_s4, deg_s5, deg_s6, deg_s7, deg_s8, deg_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else if (en) begin
			valid_s1 <= sample_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	// stage 1: line vector d = b - a, offset r = p - a
	logic signed [DW-1:0] d_s1 [3];
	logic signed [DW-1:0] r_s1 [3];
	logic signed [DW-1:0] v_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= DW'(in_b[i]) - DW'(in_a[i]);
				r_s1[i] <= DW'(in_p[i]) - DW'(in_a[i]);
				v_s1[i] <= DW'(in_v[i]);
			end
		end
	end

	// stage 2: per-axis products for L = d.d, t = r.d, u = v.d
	logic signed [SQW-1:0] dd_s2 [3];
	logic signed [SQW-1:0] rd_s2 [3];
	logic signed [SQW-1:0] vd_s2 [3];
	logic signed [DW-1:0]  d_s2 [3];
	logic signed [DW-1:0]  r_s2 [3];
	logic signed [DW-1:0]  v_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= d_s1[i] * d_s1[i];
				rd_s2[i] <= r_s1[i] * d_s1[i];
				vd_s2[i] <= v_s1[i] * d_s1[i];
				d_s2[i]  <= d_s1[i];
				r_s2[i]  <= r_s1[i];
				v_s2[i]  <= v_s1[i];
			end
		end
	end

	// stage 3: dot product sums
	logic signed [LW-1:0] len_sum;
	logic signed [LW-1:0] len_s3;
	logic signed [LW-1:0] t_s3;
	logic signed [LW-1:0] u_s3;
	logic                 deg_s3;
	logic signed [DW-1:0] d_s3 [3];
	logic signed [DW-1:0] r_s3 [3];
	logic signed [DW-1:0] v_s3 [3];

	assign len_sum = LW'(dd_s2[0]) + LW'(dd_s2[1]) + LW'(dd_s2[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			len_s3 <= len_sum;
			t_s3   <= LW'(rd_s2[0]) + LW'(rd_s2[1]) + LW'(rd_s2[2]);
			u_s3   <= LW'(vd_s2[0]) + LW'(vd_s2[1]) + LW'(vd_s2[2]);
			deg_s3 <= (len_sum == '0);
			for (int i = 0; i < 3; i++) begin
				d_s3[i] <= d_s2[i];
				r_s3[i] <= r_s2[i];
				v_s3[i] <= v_s2[i];
			end
		end
	end

	// stages 4-5: d*t, r*L, v*L, d*u per axis and 100000*L
	logic signed [MW-1:0] dt_s5 [3];
	logic signed [MW-1:0] rl_s5 [3];
	logic signed [MW-1:0] vl_s5 [3];
	logic signed [MW-1:0] du_s5 [3];
	logic signed [HW-1:0] hl_s5;

	for (genvar g = 0; g < 3; g++) begin : g_axis1
		lcf_mul #(.AW(LW), .BW(DW)) u_dt (
			.clk(clk), .en(en), .a(t_s3), .b(d_s3[g]), .p(dt_s5[g])
		);
		lcf_mul #(.AW(LW), .BW(DW)) u_rl (
			.clk(clk), .en(en), .a(len_s3), .b(r_s3[g]), .p(rl_s5[g])
		);
		lcf_mul #(.AW(LW), .BW(DW)) u_vl (
			.clk(clk), .en(en), .a(len_s3), .b(v_s3[g]), .p(vl_s5[g])
		);
		lcf_mul #(.AW(LW), .BW(DW)) u_du (
			.clk(clk), .en(en), .a(u_s3), .b(d_s3[g]), .p(du_s5[g])
		);
	end

	lcf_mul #(.AW(LW), .BW(HCW)) u_hl (
		.clk(clk), .en(en), .a(len_s3), .b(HCW'(lcf_pkg::HALF_SCALE)), .p(hl_s5)
	);

	// stage 6: spring offset and normal velocity, both scaled by L
	logic signed [PW-1:0] spring_s6 [3];
	logic signed [PW-1:0] normal_s6 [3];
	logic signed [HW-1:0] hl_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				spring_s6[i] <= PW'(dt_s5[i]) - PW'(rl_s5[i]);
				normal_s6[i] <= PW'(vl_s5[i]) - PW'(du_s5[i]);
			end
			hl_s6  <= hl_s5;
			deg_s4 <= deg_s3;
			deg_s5 <= deg_s4;
			deg_s6 <= deg_s5;
		end
	end

	// stages 7-8: apply gains
	logic signed [PW+KW-1:0]  ks_s8 [3];
	logic signed [PW+CQW-1:0] cn_s8 [3];
	logic signed [HW-1:0]     hl_s7;
	logic signed [HW-1:0]     hl_s8;

	for (genvar g = 0; g < 3; g++) begin : g_axis2
		lcf_mul #(.AW(PW), .BW(KW)) u_ks (
			.clk(clk), .en(en), .a(spring_s6[g]), .b(kq), .p(ks_s8[g])
		);
		lcf_mul #(.AW(PW), .BW(CQW)) u_cn (
			.clk(clk), .en(en), .a(normal_s6[g]), .b(cq), .p(cn_s8[g])
		);
	end

	// stage 9: numerator X
	logic signed [XW-1:0] x_s9 [3];
	logic signed [HW-1:0] hl_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			hl_s7  <= hl_s6;
			hl_s8  <= hl_s7;
			hl_s9  <= hl_s8;
			deg_s7 <= deg_s6;
			deg_s8 <= deg_s7;
			deg_s9 <= deg_s8;
			for (int i = 0; i < 3; i++) begin
				x_s9[i] <= XW'(ks_s8[i]) - XW'(cn_s8[i]);
			end
		end
	end

	// stage 10 and divider: q = floor((2X + hL) / 2hL), offset by
	// 2^(FW-1) * divisor so the quotient is nonnegative in range
	logic signed [NW-1:0] rem_s   [FW+1][3];
	logic [FW-1:0]        quo_s   [FW+1][3];
	logic signed [NW-1:0] dsor_s  [FW+1];
	logic [2:0]           sat_hi_s [FW+1];
	logic [2:0]           sat_lo_s [FW+1];
	logic [FW:0]          div_valid_s;
	logic [FW:0]          div_deg_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_valid_s <= '0;
		end else if (en) begin
			div_valid_s <= {div_valid_s[FW-1:0], valid_s9};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= (NW'(x_s9[i]) <<< 1) + NW'(hl_s9) + (NW'(hl_s9) <<< FW);
				quo_s[0][i] <= '0;
			end
			dsor_s[0]    <= NW'(hl_s9) <<< 1;
			sat_hi_s[0]  <= '0;
			sat_lo_s[0]  <= '0;
			div_deg_s[0] <= deg_s9;
		end
	end

	for (genvar j = 0; j < FW; j++) begin : g_div
		localparam int K = FW - 1 - j;

		logic signed [NW-1:0] sh;
		logic [2:0]           ge;
		logic [2:0]           hi;
		logic [2:0]           lo;

		assign sh = dsor_s[j] <<< K;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				ge[i] = (rem_s[j][i] >= sh);
				if (j == 0) begin
					hi[i] = (rem_s[j][i] >= (dsor_s[j] <<< FW));
					lo[i] = rem_s[j][i][NW-1];
				end else begin
					hi[i] = sat_hi_s[j][i];
					lo[i] = sat_lo_s[j][i];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					rem_s[j+1][i] <= ge[i] ? rem_s[j][i] - sh : rem_s[j][i];
					quo_s[j+1][i] <= quo_s[j][i] | (FW'(ge[i]) << K);
				end
				dsor_s[j+1]    <= dsor_s[j];
				sat_hi_s[j+1]  <= hi;
				sat_lo_s[j+1]  <= lo;
				div_deg_s[j+1] <= div_deg_s[j];
			end
		end
	end

	// output register: undo the offset, saturate, gate by enable and by the degenerate flag
	logic signed [FW-1:0] fsel [3];
	logic                 zero_force;

	assign zero_force = !effect_enable_q || div_deg_s[FW];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (zero_force) begin
				fsel[i] = '0;
			end else if (sat_lo_s[FW][i]) begin
				fsel[i] = {1'b1, {(FW-1){1'b0}}};
			end else if (sat_hi_s[FW][i]) begin
				fsel[i] = {1'b0, {(FW-1){1'b1}}};
			end else begin
				fsel[i] = {~quo_s[FW][i][FW-1], quo_s[FW][i][FW-2:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= div_valid_s[FW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.force_x         <= fsel[0];
			out_q.force_y         <= fsel[1];
			out_q.force_z         <= fsel[2];
			out_q.degenerate_line <= div_deg_s[FW];
		end
	end

	assign force_valid = out_valid_q;
	assign force_word  = out_q;

endmodule

// File: design/lcf_mul.sv
// two-stage signed multiplier, wide operand cut into 32-bit partial products
module lcf_mul #(
	parameter int AW = 32,
	parameter int BW = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	output logic signed [AW+BW-1:0]  p
);

	localparam int CH  = 32;
	localparam int NC  = (AW + CH - 1) / CH;
	localparam int EW  = NC * CH;
	localparam int PPW = CH + 1 + BW;
	localparam int SW  = EW + BW + 1;

	logic signed [EW-1:0]    aext;
	logic signed [CH:0]      chunk [NC];
	logic signed [PPW-1:0]   pp_s1 [NC];
	logic signed [SW-1:0]    acc;
	logic signed [AW+BW-1:0] p_s2;

	assign aext = EW'(a);

	// low chunks are unsigned, the top one carries the sign
	always_comb begin
		for (int c = 0; c < NC; c++) begin
			if (c == NC - 1) begin
				chunk[c] = {aext[c*CH+CH-1], aext[c*CH +: CH]};
			end else begin
				chunk[c] = {1'b0, aext[c*CH +: CH]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NC; c++) begin
				pp_s1[c] <= chunk[c] * b;
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int c = 0; c < NC; c++) begin
			acc = acc + (SW'(pp_s1[c]) <<< (c * CH));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= acc[AW+BW-1:0];
		end
	end

	assign p = p_s2;

endmodule

// File: dv/line_constraint_force_top_test.sv
// self-checking testbench of the line constraint force block
`timescale 1ns / 1ps

module line_constraint_force_top_test;

	localparam int CW           = lcf_pkg::COORD_WIDTH;
	localparam int FW           = lcf_pkg::FORCE_WIDTH;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = FW + 11 + 5;
	localparam int PHASE_WORDS  = 250;

	typedef logic signed [127:0] wide_t;

	// one row of the directed table: known marks a typed-in force
	typedef struct {
		lcf_pkg::sample_t s;
		bit               known;
		lcf_pkg::force_t  f;
	} row_t;

	logic             clk;
	logic             arst_n;
	logic             sample_valid;
	lcf_pkg::sample_t sample_word;
	logic             sample_stall;
	logic             force_valid;
	lcf_pkg::force_t  force_word;
	logic             force_stall;
	logic             cfg_we;
	logic [lcf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [lcf_pkg::CFG_WIDTH-1:0] cfg_data;

	// local copy of the configuration registers
	bit          fix_enable;
	logic [15:0] fix_stiffness;
	logic [15:0] fix_damping;

	lcf_pkg::force_t pending_forces[$];
	int     fail_count = 0;
	int     cycle_count = 0;
	bit     quiet;

	line_constraint_force_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_word  (sample_word),
		.sample_stall (sample_stall),
		.force_valid  (force_valid),
		.force_word   (force_word),
		.force_stall  (force_stall),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("** line_constraint_force_top: FAILED **");
			$finish;
		end
	end

	// floor division for a positive divisor
	function automatic wide_t floor_div(wide_t n, wide_t q);
		wide_t r;
		r = n / q;
		if ((n % q) != 0 && n < 0)
			r = r - 1;
		return r;
	endfunction

	// spring toward the projection on the line plus damping of normal velocity
	function automatic lcf_pkg::force_t line_force(lcf_pkg::sample_t s);
		wide_t p[3], v[3], d[3], r[3];
		wide_t len2, tdot, udot, spring, normal, x, f, kq, cq;
		wide_t fmax, fmin;
		lcf_pkg::force_t res;
		p[0] = s.tool_pos_x; p[1] = s.tool_pos_y; p[2] = s.tool_pos_z;
		v[0] = s.tool_vel_x; v[1] = s.tool_vel_y; v[2] = s.tool_vel_z;
		d[0] = wide_t'(s.line_b_x) - wide_t'(s.line_a_x);
		d[1] = wide_t'(s.line_b_y) - wide_t'(s.line_a_y);
		d[2] = wide_t'(s.line_b_z) - wide_t'(s.line_a_z);
		r[0] = p[0] - wide_t'(s.line_a_x);
		r[1] = p[1] - wide_t'(s.line_a_y);
		r[2] = p[2] - wide_t'(s.line_a_z);
		len2 = 0; tdot = 0; udot = 0;
		for (int i = 0; i < 3; i++) begin
			len2 += d[i] * d[i];
			tdot += r[i] * d[i];
			udot += v[i] * d[i];
		end
		res = '0;
		res.degenerate_line = (len2 == 0);
		if (!fix_enable || len2 == 0)
			return res;
		kq = wide_t'(fix_stiffness) * lcf_pkg::K_SCALE;
		cq = wide_t'(fix_damping);
		fmax = (wide_t'(1) <<< (FW - 1)) - 1;
		fmin = -(wide_t'(1) <<< (FW - 1));
		for (int i = 0; i < 3; i++) begin
			spring = d[i] * tdot - r[i] * len2;
			normal = v[i] * len2 - d[i] * udot;
			x = kq * spring - cq * normal;
			f = floor_div(x + x + len2 * lcf_pkg::HALF_SCALE, len2 + len2);
			f = floor_div(f, lcf_pkg::HALF_SCALE);
			if (f > fmax) f = fmax;
			if (f < fmin) f = fmin;
			case (i)
				0: res.force_x = f[FW-1:0];
				1: res.force_y = f[FW-1:0];
				default: res.force_z = f[FW-1:0];
			endcase
		end
		return res;
	endfunction

	function automatic lcf_pkg::sample_t make_sample(int px, int py, int pz,
			int vx, int vy, int vz, int ax, int ay, int az, int bx, int by, int bz);
		lcf_pkg::sample_t s;
		s.tool_pos_x = CW'(px); s.tool_pos_y = CW'(py); s.tool_pos_z = CW'(pz);
		s.tool_vel_x = CW'(vx); s.tool_vel_y = CW'(vy); s.tool_vel_z = CW'(vz);
		s.line_a_x = CW'(ax); s.line_a_y = CW'(ay); s.line_a_z = CW'(az);
		s.line_b_x = CW'(bx); s.line_b_y = CW'(by); s.line_b_z = CW'(bz);
		return s;
	endfunction

	function automatic row_t make_row(lcf_pkg::sample_t s, bit known, bit degen);
		row_t r;
		r.s = s;
		r.known = known;
		r.f = '0;
		r.f.degenerate_line = degen;
		return r;
	endfunction

	function automatic int spread(int m);
		return int'($urandom_range(0, 2 * m)) - m;
	endfunction

	// mostly a short line near the tool, some raw noise and coinciding endpoints
	function automatic lcf_pkg::sample_t random_sample();
		lcf_pkg::sample_t s;
		int kind, cx, cy, cz, ax, ay, az, span;
		kind = $urandom_range(0, 9);
		if (kind < 2) begin
			for (int i = 0; i < 12; i++)
				s[i*CW +: CW] = CW'($urandom);
			return s;
		end
		cx = $urandom; cy = $urandom; cz = $urandom;
		if ($urandom_range(0, 1)) begin
			cx = spread(100000); cy = spread(100000); cz = spread(100000);
		end
		span = $urandom_range(1, 20000);
		ax = cx + spread(4000); ay = cy + spread(4000); az = cz + spread(4000);
		s = make_sample(cx + spread(3000), cy + spread(3000), cz + spread(3000),
			spread(200000), spread(200000), spread(200000),
			ax, ay, az, ax + spread(span), ay + spread(span), az + spread(span));
		if (kind == 2) begin
			s.line_b_x = s.line_a_x;
			s.line_b_y = s.line_a_y;
			s.line_b_z = s.line_a_z;
		end
		return s;
	endfunction

	// three back to back register writes, enable held through all of them
	task automatic configure(bit en, logic [15:0] k, logic [15:0] c);
		cfg_we <= 1'b1;
		cfg_index <= lcf_pkg::REG_EFFECT_ENABLE;
		cfg_data <= {15'd0, en};
		@(posedge clk);
		cfg_index <= lcf_pkg::REG_SPRING_STIFFNESS;
		cfg_data <= k;
		@(posedge clk);
		cfg_index <= lcf_pkg::REG_DAMPING_GAIN;
		cfg_data <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		fix_enable = en;
		fix_stiffness = k;
		fix_damping = c;
	endtask

	// holds the word until accepted, then queues its expected force
	task automatic send_word(lcf_pkg::sample_t s, bit known, lcf_pkg::force_t f);
		sample_word <= s;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		pending_forces.push_back(known ? f : line_force(s));
		// occasional sender gap
		if (!quiet && $urandom_range(0, 4) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// idle the sender until the pipeline has drained
	task automatic drain();
		sample_valid <= 1'b0;
		while (pending_forces.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// receiver stalls in bursts, none once quiet
	initial begin
		force_stall = 1'b0;
		forever begin
			force_stall <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			if (!quiet) begin
				force_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
		end
	end

	// compare each accepted force word with the oldest expectation
	always @(posedge clk) begin
		lcf_pkg::force_t exp_f;
		if (arst_n && force_valid && !force_stall) begin
			if (pending_forces.size() == 0) begin
				$error("force word with nothing expected: %h", force_word);
				fail_count++;
			end else begin
				exp_f = pending_forces.pop_front();
				if (force_word.force_x !== exp_f.force_x) begin
					$error("force_x expected %0d actual %0d", exp_f.force_x, force_word.force_x);
					fail_count++;
				end
				if (force_word.force_y !== exp_f.force_y) begin
					$error("force_y expected %0d actual %0d", exp_f.force_y, force_word.force_y);
					fail_count++;
				end
				if (force_word.force_z !== exp_f.force_z) begin
					$error("force_z expected %0d actual %0d", exp_f.force_z, force_word.force_z);
					fail_count++;
				end
				if (force_word.degenerate_line !== exp_f.degenerate_line) begin
					$error("degenerate_line expected %0b actual %0b",
						exp_f.degenerate_line, force_word.degenerate_line);
					fail_count++;
				end
			end
		end
	end

	initial begin
		row_t reset_rows[$];
		row_t active_rows[$];
		bit en;
		logic [15:0] k, c;
		quiet = 1'b0;
		fix_enable = 1'b0;
		fix_stiffness = '0;
		fix_damping = '0;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample_word = '0;
		cfg_we = 1'b0;
		cfg_index = lcf_pkg::REG_EFFECT_ENABLE;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset the fixture is off: zero force, degenerate flag still live
		reset_rows.push_back(make_row(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1));
		reset_rows.push_back(make_row(make_sample(8388607, 8388607, 8388607,
			-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
			8388607, 8388607, 8388607), 1, 0));
		reset_rows.push_back(make_row(make_sample(-8388608, -8388608, -8388608,
			8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
			8388607, 8388607, 8388607), 1, 1));
		reset_rows.push_back(make_row(make_sample(500, 300, -200, 10, 20, 30,
			0, 0, 0, 1000, 0, 0), 1, 0));
		foreach (reset_rows[i])
			send_word(reset_rows[i].s, reset_rows[i].known, reset_rows[i].f);
		drain();

		// strongest gains
		configure(1'b1, 16'hFFFF, 16'hFFFF);
		active_rows.push_back(make_row(make_sample(500, 300, -200, 10, 20, 30,
			0, 0, 0, 1000, 0, 0), 0, 0));
		active_rows.push_back(make_row(make_sample(-7, 3, 1, -1, 1, -1,
			0, 0, 0, 1, 1, 1), 0, 0));
		// tool sitting on the line, moving along it
		active_rows.push_back(make_row(make_sample(20, 40, 60, 100, 200, 300,
			10, 20, 30, 30, 60, 90), 0, 0));
		// widest line, tool and velocity at the extremes: saturation
		active_rows.push_back(make_row(make_sample(8388607, -8388608, 8388607,
			-8388608, 8388607, -8388608, -8388608, -8388608, -8388608,
			8388607, 8388607, 8388607), 0, 0));
		active_rows.push_back(make_row(make_sample(-8388608, 8388607, 0,
			8388607, 8388607, 8388607, 8388607, -8388608, 0,
			-8388608, 8388607, 0), 0, 0));
		// coinciding endpoints force zero even when enabled
		active_rows.push_back(make_row(make_sample(123, -456, 789, 1000, -1000, 5,
			77, 77, 77, 77, 77, 77), 1, 1));
		active_rows.push_back(make_row(make_sample(8388607, 8388607, 8388607,
			8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
			-8388608, -8388608, -8388608), 1, 1));
		foreach (active_rows[i])
			send_word(active_rows[i].s, active_rows[i].known, active_rows[i].f);
		drain();

		// random phases; each boundary waits for every force to come back
		for (int ph = 0; ph < 7; ph++) begin
			en = 1'b1;
			k = 16'($urandom);
			c = 16'($urandom);
			case (ph)
				1: begin k = 16'hFFFF; c = 16'hFFFF; end
				2: k = 16'h0000;
				3: c = 16'h0000;
				4: begin en = 1'b0; k = 16'hFFFF; c = 16'hFFFF; end
				5: begin
					k = 16'($urandom_range(1, 200));
					c = 16'($urandom_range(1, 2000));
				end
				6: quiet = 1'b1;
				default: ;
			endcase
			configure(en, k, c);
			repeat (PHASE_WORDS)
				send_word(random_sample(), 1'b0, '0);
			drain();
		end

		if (fail_count == 0) begin
			$display("** line_constraint_force_top: PASSED **");
		end else begin
			$display("** line_constraint_force_top: FAILED **");
		end
		$finish;
	end

endmodule

// File: files.f
design/lcf_pkg.sv
design/lcf_mul.sv
design/line_constraint_force_top.sv
dv/line_constraint_force_top_test.sv
